[rtl/stpr_pkg.sv]
`timescale 1ns / 1ps

package stpr_pkg;

  // Text line storage.
  localparam int MAX_CHARS  = 512;
  localparam int ADDR_W     = $clog2(MAX_CHARS);
  localparam int LEN_W      = $clog2(MAX_CHARS + 1);
  localparam int OFS_W      = 13;

  // Register and field widths.
  localparam int STEP_W     = 4;
  localparam int WLEFT_W    = 7;
  localparam int WRIGHT_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CIDX_W     = 9;
  localparam int PAGE_W     = 3;
  localparam int COL_W      = 7;

  // Glyph geometry at double scale.
  localparam int GLYPH_W    = 10;
  localparam int GLYPH_H    = 14;
  localparam int GLYPH_TOP  = 25;
  localparam int NUM_GLYPHS = 42;

  // Reciprocal of three with 13 fraction bits; exact for the column range.
  localparam logic [23:0] RECIP3 = 24'd2731;

  // Register reset values.
  localparam logic [STEP_W-1:0]   STEP_RST   = 4'd4;
  localparam logic [WLEFT_W-1:0]  WLEFT_RST  = 7'd68;
  localparam logic [WRIGHT_W-1:0] WRIGHT_RST = 8'd126;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_READ = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP   = 2'd0,
    CFG_WLEFT  = 2'd1,
    CFG_WRIGHT = 2'd2
  } cfg_e;

  // Special glyph slots.
  localparam logic [5:0] G_DIGIT0 = 6'd26;
  localparam logic [5:0] G_SPACE  = 6'd36;
  localparam logic [5:0] G_DOT    = 6'd37;
  localparam logic [5:0] G_BANG   = 6'd38;
  localparam logic [5:0] G_COLON  = 6'd39;
  localparam logic [5:0] G_DASH   = 6'd40;
  localparam logic [5:0] G_QUEST  = 6'd41;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CIDX_W-1:0] char_index;
    logic [7:0]        char_code;
    logic              last_char;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  column;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              draw;
    logic [2:0]        scol;
    logic [PAGE_W-1:0] page;
  } fetch_t;

  typedef struct packed {
    logic [OFS_W-1:0] ofs;
    logic [LEN_W-1:0] len;
  } status_t;

  // Font rows, top row in the high bits; bit 4 of a row is the leftmost pixel.
  localparam logic [34:0] FONT [NUM_GLYPHS] = '{
    {5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F, 5'h00},
    {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h00},
    {5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h0E, 5'h00},
    {5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h00},
    {5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E, 5'h00},
    {5'h06, 5'h09, 5'h08, 5'h1C, 5'h08, 5'h08, 5'h00},
    {5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01, 5'h0E, 5'h00},
    {5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h00},
    {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h0E, 5'h00},
    {5'h02, 5'h00, 5'h06, 5'h02, 5'h12, 5'h0C, 5'h00},
    {5'h10, 5'h10, 5'h12, 5'h1C, 5'h12, 5'h11, 5'h00},
    {5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E, 5'h00},
    {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h00},
    {5'h00, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h00},
    {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00},
    {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10},
    {5'h00, 5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01, 5'h01},
    {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h00},
    {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h1E, 5'h00},
    {5'h08, 5'h08, 5'h1C, 5'h08, 5'h09, 5'h06, 5'h00},
    {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0F, 5'h00},
    {5'h00, 5'h00, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h00},
    {5'h00, 5'h00, 5'h11, 5'h15, 5'h15, 5'h0A, 5'h00},
    {5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
    {5'h00, 5'h00, 5'h11, 5'h0F, 5'h01, 5'h0E, 5'h00},
    {5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h1F, 5'h00},
    {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
    {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04},
    {5'h00, 5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00},
    {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
    {5'h0E, 5'h11, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04}
  };

  // Map a character code to its font slot; upper case folds to lower case.
  function automatic logic [5:0] glyph_slot(input logic [7:0] code);
    logic [7:0] c;
    logic [5:0] slot;
    c = code;
    if (c >= 8'h41 && c <= 8'h5A) begin
      c = c + 8'h20;
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      slot = 6'(c - 8'h61);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      slot = G_DIGIT0 + 6'(c - 8'h30);
    end else if (c == 8'h20) begin
      slot = G_SPACE;
    end else if (c == 8'h2E) begin
      slot = G_DOT;
    end else if (c == 8'h21) begin
      slot = G_BANG;
    end else if (c == 8'h3A) begin
      slot = G_COLON;
    end else if (c == 8'h2D) begin
      slot = G_DASH;
    end else begin
      slot = G_QUEST;
    end
    return slot;
  endfunction

endpackage

[rtl/stpr_if.sv]
`timescale 1ns / 1ps

// Command channel into the renderer.
interface stpr_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [stpr_pkg::CIDX_W-1:0] char_index;
  logic [7:0]                 char_code;
  logic                       last_char;
  logic [stpr_pkg::PAGE_W-1:0] page;
  logic [stpr_pkg::COL_W-1:0]  column;

  modport source (
    output valid, cmd, char_index, char_code, last_char, page, column,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_index, char_code, last_char, page, column,
    output ready
  );
endinterface

// Result channel out of the renderer.
interface stpr_out_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 pixel_byte;
  logic [stpr_pkg::OFS_W-1:0] scroll_position;
  logic [stpr_pkg::LEN_W-1:0] stored_length;

  modport source (
    output valid, pixel_byte, scroll_position, stored_length,
    input  ready
  );
  modport sink (
    input  valid, pixel_byte, scroll_position, stored_length,
    output ready
  );
endinterface

[rtl/scrolling_text_page_renderer.sv]
`timescale 1ns / 1ps

// Scrolling text page renderer.
// Commands arrive as items on in_ch: load one character, read one frame
// byte of the 128x64 page-organized frame, or advance the marquee by one
// tick. Every item yields exactly one result item on out_ch with the frame
// byte (zero except for reads), the scroll offset after the item and the
// stored line length. Registers must be written on the cfg port only while idle;
// the block does not enforce this. The input register takes the item, a
// second stage updates state and reads the text store, and the output
// register holds the font lookup. One item is accepted per cycle while
// results are taken; the registered text store read is what adds the
// middle stage.
// When out_ch stalls, the whole pipeline holds and in_ch.ready drops as
// soon as the output register is full and not being taken.
// Reset clears the line length, the scroll offset and all valid bits and
// loads the register reset values; the text store itself is not cleared
// and needs no clearing pass.
module scrolling_text_page_renderer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  stpr_in_if.sink                         in_ch,
  stpr_out_if.source                      out_ch
);

  logic               adv;
  logic               in_fire;
  logic               a_valid_q;
  stpr_pkg::item_t    a_item_q;
  logic               b_valid_q;
  stpr_pkg::fetch_t   b_fetch_q;
  stpr_pkg::status_t  b_status_q;
  logic               out_valid_q;
  logic [7:0]         out_pixel_q;
  stpr_pkg::status_t  out_status_q;

  stpr_pkg::mem_req_t mem_req;
  stpr_pkg::fetch_t   fetch;
  stpr_pkg::status_t  status;
  logic [7:0]         text_code;
  logic [7:0]         pixel;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid_q || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= '{cmd:        in_ch.cmd,
                    char_index: in_ch.char_index,
                    char_code:  in_ch.char_code,
                    last_char:  in_ch.last_char,
                    page:       in_ch.page,
                    column:     in_ch.column};
    end
  end

  stpr_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (adv && a_valid_q),
    .item_i     (a_item_q),
    .mem_req_o  (mem_req),
    .fetch_o    (fetch),
    .status_o   (status)
  );

  stpr_text_mem u_text_mem (
    .clk_i   (clk_i),
    .en_i    (adv),
    .req_i   (mem_req),
    .rdata_o (text_code)
  );

  // Fetch stage, aligned with the registered text store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_fetch_q  <= fetch;
      b_status_q <= status;
    end
  end

  stpr_glyph u_glyph (
    .fetch_i (b_fetch_q),
    .code_i  (text_code),
    .pixel_o (pixel)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pixel_q  <= pixel;
      out_status_q <= b_status_q;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.pixel_byte      = out_pixel_q;
  assign out_ch.scroll_position = out_status_q.ofs;
  assign out_ch.stored_length   = out_status_q.len;

  // The line never grows past the store.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_status_q.len <= stpr_pkg::LEN_W'(stpr_pkg::MAX_CHARS)))
    else $error("stored length beyond the text store");

  // Lit pixels only come from a non-empty line.
  a_lit_needs_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_pixel_q != 8'h00)) |-> (out_status_q.len != '0))
    else $error("pixels drawn from an empty line");

endmodule

[rtl/stpr_text_mem.sv]
`timescale 1ns / 1ps

// Text line store: one write port and one registered read port.
module stpr_text_mem (
  input  logic               clk_i,
  input  logic               en_i,
  input  stpr_pkg::mem_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [stpr_pkg::MAX_CHARS];
  logic [7:0] rdata_q;

  // The read data holds while the pipeline is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i && req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (en_i) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/stpr_state.sv]
`timescale 1ns / 1ps

// Configuration registers, line length and scroll offset, and the column
// decode that turns a frame byte request into a text store address.
module stpr_state (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [stpr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [stpr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                fire_i,
  input  stpr_pkg::item_t                     item_i,
  output stpr_pkg::mem_req_t                  mem_req_o,
  output stpr_pkg::fetch_t                    fetch_o,
  output stpr_pkg::status_t                   status_o
);

  logic [stpr_pkg::STEP_W-1:0]   step_q;
  logic [stpr_pkg::WLEFT_W-1:0]  wleft_q;
  logic [stpr_pkg::WRIGHT_W-1:0] wright_q;
  logic [stpr_pkg::OFS_W-1:0]    ofs_q, ofs_d;
  logic [stpr_pkg::LEN_W-1:0]    len_q, len_d;

  stpr_pkg::cmd_e                cmd;
  logic [7:0]                    win_w;
  logic [13:0]                   loop_len;
  logic [13:0]                   ofs_sum;
  logic                          load_ok;
  logic [7:0]                    load_code;

  logic [14:0]                   rel;
  logic [11:0]                   rel_q4;
  logic [23:0]                   prod;
  logic [9:0]                    idx;
  logic [13:0]                   idx_x12;
  logic [13:0]                   in_glyph_full;
  logic [3:0]                    in_glyph;
  logic                          in_window;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= stpr_pkg::STEP_RST;
      wleft_q  <= stpr_pkg::WLEFT_RST;
      wright_q <= stpr_pkg::WRIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (stpr_pkg::cfg_e'(cfg_idx_i))
        stpr_pkg::CFG_STEP:   step_q   <= cfg_data_i[stpr_pkg::STEP_W-1:0];
        stpr_pkg::CFG_WLEFT:  wleft_q  <= cfg_data_i[stpr_pkg::WLEFT_W-1:0];
        stpr_pkg::CFG_WRIGHT: wright_q <= cfg_data_i[stpr_pkg::WRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd = stpr_pkg::cmd_e'(item_i.cmd);

  // Window width and the full marquee loop: text width plus window width.
  assign win_w    = (wright_q > {1'b0, wleft_q}) ? (wright_q - {1'b0, wleft_q}) : '0;
  assign loop_len = {len_q, 3'b000} + {1'b0, len_q, 2'b00} + {6'b0, win_w};
  assign ofs_sum  = {1'b0, ofs_q} + {10'b0, step_q};

  // Loads store CR and LF as space.
  assign load_ok   = ({1'b0, item_i.char_index} < stpr_pkg::LEN_W'(stpr_pkg::MAX_CHARS));
  assign load_code = (item_i.char_code == 8'h0D || item_i.char_code == 8'h0A) ?
                     8'h20 : item_i.char_code;

  // Next line length and offset.
  always_comb begin
    len_d = len_q;
    ofs_d = ofs_q;
    case (cmd)
      stpr_pkg::CMD_LOAD: begin
        if (load_ok && item_i.last_char) begin
          len_d = {1'b0, item_i.char_index} + 1'b1;
          ofs_d = '0;
        end
      end
      stpr_pkg::CMD_TICK: begin
        if (len_q != '0) begin
          ofs_d = (ofs_sum >= loop_len) ? '0 : ofs_sum[stpr_pkg::OFS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= '0;
      len_q <= '0;
    end else if (fire_i) begin
      ofs_q <= ofs_d;
      len_q <= len_d;
    end
  end

  // Column decode: position in the line, then character and column in glyph.
  // Division by twelve is a shift by two and a multiply by a reciprocal of 3.
  assign rel           = {8'b0, item_i.column} + {2'b0, ofs_q} - {7'b0, wright_q};
  assign rel_q4        = rel[13:2];
  assign prod          = 24'(rel_q4) * stpr_pkg::RECIP3;
  assign idx           = prod[22:13];
  assign idx_x12       = {1'b0, idx, 3'b000} + {2'b0, idx, 2'b00};
  assign in_glyph_full = rel[13:0] - idx_x12;
  assign in_glyph      = in_glyph_full[3:0];
  assign in_window     = (item_i.column >= wleft_q) && ({1'b0, item_i.column} < wright_q);

  assign fetch_o.draw = (cmd == stpr_pkg::CMD_READ) && in_window && !rel[14] &&
                        (in_glyph < 4'(stpr_pkg::GLYPH_W)) &&
                        (idx < len_q);
  assign fetch_o.scol = in_glyph[3:1];
  assign fetch_o.page = item_i.page;

  assign mem_req_o.we    = fire_i && (cmd == stpr_pkg::CMD_LOAD) && load_ok;
  assign mem_req_o.waddr = item_i.char_index[stpr_pkg::ADDR_W-1:0];
  assign mem_req_o.wdata = load_code;
  assign mem_req_o.raddr = idx[stpr_pkg::ADDR_W-1:0];

  assign status_o.ofs = ofs_d;
  assign status_o.len = len_d;

  // An empty line never scrolls.
  a_empty_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) |-> (ofs_q == '0))
    else $error("scroll offset moved with an empty line");

endmodule

[rtl/stpr_glyph.sv]
`timescale 1ns / 1ps

// Font lookup: one glyph column, spread over the eight rows of a page.
module stpr_glyph (
  input  stpr_pkg::fetch_t fetch_i,
  input  logic [7:0]       code_i,
  output logic [7:0]       pixel_o
);

  logic [5:0]  slot;
  logic [34:0] rows;
  logic [6:0]  col_bits;

  assign slot = stpr_pkg::glyph_slot(code_i);
  assign rows = stpr_pkg::FONT[slot];

  // One bit of each font row at the selected glyph column.
  always_comb begin
    for (int r = 0; r < 7; r++) begin
      col_bits[r] = rows[(6 - r) * 5 + 4 - int'(fetch_i.scol)];
    end
  end

  // Each font row covers two frame rows starting at the glyph top.
  always_comb begin
    logic [5:0] y;
    logic [5:0] dy;
    for (int n = 0; n < 8; n++) begin
      y  = {fetch_i.page, 3'(n)};
      dy = y - 6'(stpr_pkg::GLYPH_TOP);
      pixel_o[n] = fetch_i.draw &&
                   (y >= 6'(stpr_pkg::GLYPH_TOP)) &&
                   (y < 6'(stpr_pkg::GLYPH_TOP + stpr_pkg::GLYPH_H)) &&
                   col_bits[dy[3:1]];
    end
  end

endmodule
